FILE: sv/nms_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register indexes, neighbour tables and divider types for
// the neighbour mean smoother. No dependencies.
package nms_pkg;

    localparam int DATA_W     = 32;
    localparam int ROW_W      = 16;
    localparam int COL_W      = 6;
    localparam int IDX_W      = 22;
    localparam int SUM_W      = 35;
    localparam int PROD_W     = 40;
    localparam int CNT_W      = 4;
    localparam int OFF_W      = 8;
    localparam int SLOT_W     = 9;
    localparam int RES_CNT_W  = 7;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int DIV_RADIX_BITS = 8;
    localparam int DIV_CYCLES     = PROD_W / DIV_RADIX_BITS;
    localparam int DIV_STEP_W     = 3;

    localparam logic [RES_CNT_W-1:0] MAX_OUT = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 4'd1;

    localparam logic [1:0] REL_PREV = 2'd0;
    localparam logic [1:0] REL_SAME = 2'd1;
    localparam logic [1:0] REL_NEXT = 2'd2;

    localparam logic [1:0] NB_ROW [8] = '{REL_PREV, REL_PREV, REL_PREV, REL_SAME,
                                          REL_SAME, REL_NEXT, REL_NEXT, REL_NEXT};
    localparam logic [1:0] NB_COL [8] = '{REL_PREV, REL_SAME, REL_NEXT, REL_PREV,
                                          REL_NEXT, REL_PREV, REL_SAME, REL_NEXT};

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } t_div_rsp;

endpackage

FILE: sv/neighbour_mean_smooth.sv
`timescale 1ns / 1ps
// Top level of the neighbour mean smoother: history memory, sequencer and
// result registers. Depends on nms_pkg and nms_div.
//
// Elements arrive in row-major order and are kept in a history memory with
// one write port and one read port; each result is the mean of the in-matrix
// neighbours, excluding the centre, given in tenths and truncated toward
// zero, and leaves once its lower-right neighbour has arrived, in element
// order. One item is handled at a time. For each result it completes, an
// item runs eight neighbour reads through the one memory read port, a drain
// step, two scaling steps, the divider that produces eight quotient bits
// per cycle, and a final step to saturate and post it. The last element of
// a matrix completes up to col_count + 2 results (zero columns count as
// one). A finished result waits in the output register while the next item
// is accepted. A write to either size register restarts the matrix. A
// result beyond 64 for one item is held and given first with the next item.
module neighbour_mean_smooth #(
    parameter int MAX_COLS      = 63,
    parameter int HISTORY_DEPTH = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [nms_pkg::DATA_W-1:0]   i_pixel_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [nms_pkg::DATA_W-1:0]   o_mean_tenths,
    output logic                                o_no_neighbours,
    output logic                                o_saturated,
    output logic                                o_last_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [nms_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [nms_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int AddrW   = $clog2(HISTORY_DEPTH);
    localparam int HistCap = (HISTORY_DEPTH - 2) / 2;
    localparam int ColCap  = (MAX_COLS < HistCap) ? MAX_COLS : HistCap;
    localparam int IdxXW   = nms_pkg::IDX_W + 1;
    localparam int SlotW   = nms_pkg::SLOT_W;
    localparam int OffW    = nms_pkg::OFF_W;
    localparam int DataW   = nms_pkg::DATA_W;
    localparam int SumW    = nms_pkg::SUM_W;
    localparam int ProdW   = nms_pkg::PROD_W;
    localparam logic signed [SlotW-1:0] DepthS = SlotW'(HISTORY_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_BACKLOG, S_CHECK, S_READ, S_DRAIN,
        S_SCALE, S_ABS, S_DIV, S_FIN, S_WRITE
    } t_state;

    t_state r_state;

    logic [nms_pkg::ROW_W-1:0] r_row_count;
    logic [nms_pkg::COL_W-1:0] r_col_count;
    logic [nms_pkg::ROW_W-1:0] r_row_pos;
    logic [nms_pkg::COL_W-1:0] r_col_pos;
    logic [nms_pkg::IDX_W-1:0] r_pos_idx;
    logic [AddrW-1:0]          r_pos_slot;
    logic [nms_pkg::ROW_W-1:0] r_em_row;
    logic [nms_pkg::COL_W-1:0] r_em_col;
    logic [nms_pkg::IDX_W-1:0] r_em_idx;
    logic [AddrW-1:0]          r_em_slot;

    logic [DataW-1:0]                  r_cur_val;
    logic                              r_final;
    logic [nms_pkg::RES_CNT_W-1:0]     r_res_cnt;
    logic                              r_to_bl;
    logic [2:0]                        r_k;
    logic signed [SumW-1:0]            r_sum;
    logic [nms_pkg::CNT_W-1:0]         r_nb_cnt;
    logic                              r_acc_en;
    logic                              r_acc_cur;
    logic signed [ProdW-1:0]           r_prod;
    logic                              r_neg;

    logic [DataW-1:0] r_hist [HISTORY_DEPTH];
    logic [DataW-1:0] r_rd_data;

    logic             r_bl_valid;
    logic [DataW-1:0] r_bl_mean;
    logic             r_bl_nonb;
    logic             r_bl_sat;
    logic             r_bl_last;

    logic             r_out_valid;
    logic [DataW-1:0] r_out_mean;
    logic             r_out_nonb;
    logic             r_out_sat;
    logic             r_out_last;

    logic [nms_pkg::ROW_W-1:0] rows_m1;
    logic [nms_pkg::COL_W-1:0] eff_cols;
    logic [nms_pkg::COL_W-1:0] cols_m1;
    logic                      pos_last;
    logic [IdxXW-1:0]          lag_sum;
    logic                      due;
    logic                      in_fire;
    logic                      cfg_fire;
    logic                      cfg_restart;
    logic                      out_free;
    logic                      out_post;
    logic [AddrW-1:0]          pos_slot_inc;
    logic [AddrW-1:0]          em_slot_inc;

    logic [1:0]                nb_rrel;
    logic [1:0]                nb_crel;
    logic                      nb_valid;
    logic signed [OffW-1:0]    cols_s;
    logic signed [OffW-1:0]    row_off;
    logic signed [OffW-1:0]    col_off;
    logic signed [OffW-1:0]    nb_off;
    logic [IdxXW-1:0]          nb_idx;
    logic                      nb_is_cur;
    logic signed [SlotW-1:0]   slot_raw;
    logic signed [SlotW-1:0]   slot_fix;
    logic [AddrW-1:0]          nb_addr;
    logic [DataW-1:0]          acc_data;

    logic [DataW-1:0]          res_mean;
    logic                      res_nonb;
    logic                      res_sat;
    logic                      res_last;
    logic                      pos_ovf;
    logic                      neg_ovf;
    logic [ProdW-1:0]          quo;

    nms_pkg::t_div_req div_req;
    nms_pkg::t_div_rsp div_rsp;

    always_comb begin
        eff_cols = (r_col_count == '0) ? nms_pkg::COL_W'(1) : r_col_count;
        if (eff_cols > nms_pkg::COL_W'(ColCap)) begin
            eff_cols = nms_pkg::COL_W'(ColCap);
        end
    end

    assign rows_m1  = (r_row_count == '0) ? '0 : r_row_count - 1'b1;
    assign cols_m1  = eff_cols - 1'b1;
    assign pos_last = (r_row_pos == rows_m1) && (r_col_pos == cols_m1);

    assign lag_sum = {1'b0, r_em_idx} + IdxXW'(eff_cols) + IdxXW'(1);
    assign due     = (r_em_idx <= r_pos_idx) && (r_final || (lag_sum <= {1'b0, r_pos_idx}));

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign cfg_restart = cfg_fire && ((i_cfg_index == nms_pkg::CFG_ROW_COUNT) ||
                                      (i_cfg_index == nms_pkg::CFG_COL_COUNT));
    assign out_free    = !r_out_valid || i_out_ready;
    assign out_post    = out_free && ((r_state == S_BACKLOG) ||
                                      ((r_state == S_FIN) && !r_to_bl));

    assign pos_slot_inc = (r_pos_slot == AddrW'(HISTORY_DEPTH - 1)) ? '0 : r_pos_slot + 1'b1;
    assign em_slot_inc  = (r_em_slot == AddrW'(HISTORY_DEPTH - 1)) ? '0 : r_em_slot + 1'b1;

    // Neighbour k of the element whose result is being formed.
    assign nb_rrel = nms_pkg::NB_ROW[r_k];
    assign nb_crel = nms_pkg::NB_COL[r_k];
    assign cols_s  = $signed({2'b00, eff_cols});

    always_comb begin
        case (nb_rrel)
            nms_pkg::REL_PREV: row_off = -cols_s;
            nms_pkg::REL_NEXT: row_off = cols_s;
            default:           row_off = '0;
        endcase
        case (nb_crel)
            nms_pkg::REL_PREV: col_off = -OffW'(1);
            nms_pkg::REL_NEXT: col_off = OffW'(1);
            default:           col_off = '0;
        endcase
    end

    assign nb_valid = !((nb_rrel == nms_pkg::REL_PREV) && (r_em_row == '0)) &&
                      !((nb_rrel == nms_pkg::REL_NEXT) && (r_em_row == rows_m1)) &&
                      !((nb_crel == nms_pkg::REL_PREV) && (r_em_col == '0)) &&
                      !((nb_crel == nms_pkg::REL_NEXT) && (r_em_col == cols_m1));

    assign nb_off    = row_off + col_off;
    assign nb_idx    = {1'b0, r_em_idx} + {{(IdxXW - OffW){nb_off[OffW-1]}}, nb_off};
    assign nb_is_cur = (nb_idx == {1'b0, r_pos_idx});
    assign slot_raw  = $signed(SlotW'(r_em_slot)) + SlotW'(nb_off);

    always_comb begin
        if (slot_raw[SlotW-1]) begin
            slot_fix = slot_raw + DepthS;
        end else if (slot_raw >= DepthS) begin
            slot_fix = slot_raw - DepthS;
        end else begin
            slot_fix = slot_raw;
        end
    end

    assign nb_addr  = slot_fix[AddrW-1:0];
    assign acc_data = r_acc_cur ? r_cur_val : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_hist[r_pos_slot] <= r_cur_val;
        end
        r_rd_data <= r_hist[nb_addr];
    end

    assign div_req.start    = (r_state == S_ABS);
    assign div_req.dividend = r_prod[ProdW-1] ? (~r_prod + 1'b1) : r_prod;
    assign div_req.divisor  = r_nb_cnt;

    nms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign quo     = div_rsp.quotient;
    assign pos_ovf = |quo[ProdW-1:DataW-1];
    assign neg_ovf = (|quo[ProdW-1:DataW]) || (quo[DataW-1] && (|quo[DataW-2:0]));

    always_comb begin
        res_last = (r_em_row == rows_m1) && (r_em_col == cols_m1);
        res_nonb = 1'b0;
        res_sat  = 1'b0;
        res_mean = '0;
        if (r_nb_cnt == '0) begin
            res_nonb = 1'b1;
        end else if (!r_neg) begin
            res_sat  = pos_ovf;
            res_mean = pos_ovf ? {1'b0, {(DataW - 1){1'b1}}} : quo[DataW-1:0];
        end else begin
            res_sat  = neg_ovf;
            res_mean = neg_ovf ? {1'b1, {(DataW - 1){1'b0}}} : (~quo[DataW-1:0] + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_count <= nms_pkg::ROW_W'(1);
            r_col_count <= nms_pkg::COL_W'(1);
            r_row_pos   <= '0;
            r_col_pos   <= '0;
            r_pos_idx   <= '0;
            r_pos_slot  <= '0;
            r_em_row    <= '0;
            r_em_col    <= '0;
            r_em_idx    <= '0;
            r_em_slot   <= '0;
            r_final     <= 1'b0;
            r_res_cnt   <= '0;
            r_to_bl     <= 1'b0;
            r_k         <= '0;
            r_nb_cnt    <= '0;
            r_acc_en    <= 1'b0;
            r_bl_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !out_post) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (cfg_fire) begin
                        case (i_cfg_index)
                            nms_pkg::CFG_ROW_COUNT: r_row_count <= i_cfg_data[nms_pkg::ROW_W-1:0];
                            nms_pkg::CFG_COL_COUNT: r_col_count <= i_cfg_data[nms_pkg::COL_W-1:0];
                            default: ;
                        endcase
                        if (cfg_restart) begin
                            r_row_pos  <= '0;
                            r_col_pos  <= '0;
                            r_pos_idx  <= '0;
                            r_pos_slot <= '0;
                            r_em_row   <= '0;
                            r_em_col   <= '0;
                            r_em_idx   <= '0;
                            r_em_slot  <= '0;
                        end
                    end else if (in_fire) begin
                        r_cur_val <= i_pixel_value;
                        r_final   <= pos_last;
                        r_res_cnt <= '0;
                        r_state   <= r_bl_valid ? S_BACKLOG : S_CHECK;
                    end
                end
                S_BACKLOG: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_mean  <= r_bl_mean;
                        r_out_nonb  <= r_bl_nonb;
                        r_out_sat   <= r_bl_sat;
                        r_out_last  <= r_bl_last;
                        r_bl_valid  <= 1'b0;
                        r_res_cnt   <= nms_pkg::RES_CNT_W'(1);
                        r_state     <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (due && ((r_res_cnt < nms_pkg::MAX_OUT) || !r_bl_valid)) begin
                        r_to_bl  <= (r_res_cnt >= nms_pkg::MAX_OUT);
                        r_k      <= '0;
                        r_sum    <= '0;
                        r_nb_cnt <= '0;
                        r_acc_en <= 1'b0;
                        r_state  <= S_READ;
                    end else begin
                        r_state <= S_WRITE;
                    end
                end
                S_READ: begin
                    if (r_acc_en) begin
                        r_sum <= r_sum + SumW'($signed(acc_data));
                    end
                    r_acc_en  <= nb_valid;
                    r_acc_cur <= nb_is_cur;
                    if (nb_valid) begin
                        r_nb_cnt <= r_nb_cnt + 1'b1;
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == 3'd7) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_acc_en) begin
                        r_sum <= r_sum + SumW'($signed(acc_data));
                    end
                    r_acc_en <= 1'b0;
                    r_state  <= S_SCALE;
                end
                S_SCALE: begin
                    r_prod  <= (ProdW'(r_sum) <<< 3) + (ProdW'(r_sum) <<< 1);
                    r_state <= (r_nb_cnt == '0) ? S_FIN : S_ABS;
                end
                S_ABS: begin
                    r_neg   <= r_prod[ProdW-1];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_to_bl || out_free) begin
                        if (r_to_bl) begin
                            r_bl_valid <= 1'b1;
                            r_bl_mean  <= res_mean;
                            r_bl_nonb  <= res_nonb;
                            r_bl_sat   <= res_sat;
                            r_bl_last  <= res_last;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out_mean  <= res_mean;
                            r_out_nonb  <= res_nonb;
                            r_out_sat   <= res_sat;
                            r_out_last  <= res_last;
                            r_res_cnt   <= r_res_cnt + 1'b1;
                        end
                        r_em_idx  <= r_em_idx + 1'b1;
                        r_em_slot <= em_slot_inc;
                        if (r_em_col == cols_m1) begin
                            r_em_col <= '0;
                            r_em_row <= r_em_row + 1'b1;
                        end else begin
                            r_em_col <= r_em_col + 1'b1;
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_WRITE: begin
                    if (r_final) begin
                        r_row_pos  <= '0;
                        r_col_pos  <= '0;
                        r_pos_idx  <= '0;
                        r_pos_slot <= '0;
                        r_em_row   <= '0;
                        r_em_col   <= '0;
                        r_em_idx   <= '0;
                        r_em_slot  <= '0;
                    end else begin
                        r_pos_idx  <= r_pos_idx + 1'b1;
                        r_pos_slot <= pos_slot_inc;
                        if (r_col_pos == cols_m1) begin
                            r_col_pos <= '0;
                            r_row_pos <= r_row_pos + 1'b1;
                        end else begin
                            r_col_pos <= r_col_pos + 1'b1;
                        end
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_mean_tenths   = r_out_mean;
    assign o_no_neighbours = r_out_nonb;
    assign o_saturated     = r_out_sat;
    assign o_last_result   = r_out_last;

`ifndef SYNTHESIS
    a_nb_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nb_cnt <= nms_pkg::CNT_W'(8))
        else $error("neighbour count above eight");

    a_res_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_cnt <= nms_pkg::MAX_OUT)
        else $error("more results in one transaction than the output limit");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("input taken while a transaction is in progress");

    a_emit_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_em_idx <= r_pos_idx))
        else $error("result index ahead of input position");
`endif

endmodule

FILE: sv/nms_div.sv
`timescale 1ns / 1ps
// Unsigned divider of a 40-bit magnitude by a small count, eight quotient
// bits per cycle. Depends on nms_pkg.
module nms_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nms_pkg::t_div_req i_req,
    output nms_pkg::t_div_rsp o_rsp
);

    logic [nms_pkg::PROD_W-1:0]     r_work;
    logic [nms_pkg::CNT_W-1:0]      r_rem;
    logic [nms_pkg::DIV_STEP_W-1:0] r_step;
    logic                           r_busy;
    logic                           r_done;
    logic [nms_pkg::PROD_W-1:0]     n_work;
    logic [nms_pkg::CNT_W-1:0]      n_rem;

    always_comb begin
        logic [nms_pkg::CNT_W-1:0] trial;
        trial  = '0;
        n_work = r_work;
        n_rem  = r_rem;
        for (int i = 0; i < nms_pkg::DIV_RADIX_BITS; i++) begin
            trial  = {n_rem[nms_pkg::CNT_W-2:0], n_work[nms_pkg::PROD_W-1]};
            n_work = {n_work[nms_pkg::PROD_W-2:0], 1'b0};
            if (trial >= i_req.divisor) begin
                n_rem     = trial - i_req.divisor;
                n_work[0] = 1'b1;
            end else begin
                n_rem = trial;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_req.start) begin
            r_work <= i_req.dividend;
            r_rem  <= '0;
            r_step <= '0;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
            r_step <= r_step + 1'b1;
            if (r_step == nms_pkg::DIV_STEP_W'(nms_pkg::DIV_CYCLES - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_work;

endmodule

FILE: test/neighbour_mean_smooth_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for neighbour_mean_smooth: streams matrices through the block and
// checks every neighbour mean against a built-in predictor. Depends on nms_pkg and the RTL.
module neighbour_mean_smooth_test;
    import nms_pkg::*;

    localparam int RING_DEPTH = 128;
    localparam longint TENTHS_MAX = 64'sd2147483647;
    localparam longint TENTHS_MIN = -64'sd2147483648;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd14;
    localparam logic [DATA_W-1:0] PIXEL_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] PIXEL_MIN = 32'h8000_0000;

    typedef struct {
        logic signed [DATA_W-1:0] mean;
        logic                     no_nb;
        logic                     sat;
        logic                     last;
    } mean_result_t;

    class mean_scoreboard;
        logic [DATA_W-1:0] history [RING_DEPTH];
        int unsigned       row_pos;
        int unsigned       col_pos;
        int unsigned       emit_idx;
        logic [ROW_W-1:0]  rows_reg;
        logic [COL_W-1:0]  cols_reg;
        bit                held_valid;
        mean_result_t      held;
        mean_result_t      due_means [$];
        int                errors;

        function new();
            rows_reg   = 1;
            cols_reg   = 1;
            row_pos    = 0;
            col_pos    = 0;
            emit_idx   = 0;
            held_valid = 0;
            errors     = 0;
        endfunction

        function mean_result_t neighbour_mean(int unsigned e, int unsigned p,
                                              logic [DATA_W-1:0] v,
                                              int unsigned rows, int unsigned cols);
            int                       r;
            int                       c;
            int                       nr;
            int                       nc;
            int                       cnt;
            int unsigned              idx;
            longint                   sum;
            longint                   tenths;
            logic signed [DATA_W-1:0] nb;
            mean_result_t             res;
            r   = e / cols;
            c   = e % cols;
            sum = 0;
            cnt = 0;
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    nr = r + dr;
                    nc = c + dc;
                    if (!(dr == 0 && dc == 0) && nr >= 0 && nr < int'(rows)
                            && nc >= 0 && nc < int'(cols)) begin
                        idx = nr * cols + nc;
                        nb  = (idx == p) ? v : history[idx % RING_DEPTH];
                        sum += nb;
                        cnt++;
                    end
                end
            end
            res.mean  = 0;
            res.no_nb = 0;
            res.sat   = 0;
            res.last  = (e == rows * cols - 1);
            if (cnt == 0) begin
                res.no_nb = 1;
            end else begin
                tenths = (sum * 10) / longint'(cnt);
                if (tenths > TENTHS_MAX) begin
                    tenths  = TENTHS_MAX;
                    res.sat = 1;
                end else if (tenths < TENTHS_MIN) begin
                    tenths  = TENTHS_MIN;
                    res.sat = 1;
                end
                res.mean = tenths[DATA_W-1:0];
            end
            return res;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_ROW_COUNT) begin
                rows_reg = data;
            end else if (idx == CFG_COL_COUNT) begin
                cols_reg = data[COL_W-1:0];
            end else begin
                return;
            end
            row_pos  = 0;
            col_pos  = 0;
            emit_idx = 0;
        endfunction

        function void note_pixel(logic [DATA_W-1:0] v);
            int unsigned rows;
            int unsigned cols;
            int unsigned total;
            int unsigned p;
            bit          last_elem;
            int          n;
            rows      = (rows_reg == 0) ? 1 : rows_reg;
            cols      = (cols_reg == 0) ? 1 : cols_reg;
            total     = rows * cols;
            p         = row_pos * cols + col_pos;
            last_elem = (p == total - 1);
            n         = 0;
            if (held_valid) begin
                due_means.push_back(held);
                held_valid = 0;
                n = 1;
            end
            while (emit_idx <= p && (last_elem || emit_idx + cols + 1 <= p)) begin
                if (n < MAX_OUT) begin
                    due_means.push_back(neighbour_mean(emit_idx, p, v, rows, cols));
                    n++;
                end else if (!held_valid) begin
                    held       = neighbour_mean(emit_idx, p, v, rows, cols);
                    held_valid = 1;
                end else begin
                    break;
                end
                emit_idx++;
            end
            history[p % RING_DEPTH] = v;
            if (last_elem) begin
                row_pos  = 0;
                col_pos  = 0;
                emit_idx = 0;
            end else if (col_pos + 1 >= cols) begin
                col_pos = 0;
                row_pos++;
            end else begin
                col_pos++;
            end
        endfunction

        function void check_result(mean_result_t got);
            mean_result_t want;
            if (due_means.size() == 0) begin
                $error("unexpected result: mean_tenths %0d", got.mean);
                errors++;
                return;
            end
            want = due_means.pop_front();
            if (got.mean !== want.mean) begin
                $error("mean_tenths: expected %0d, actual %0d", want.mean, got.mean);
                errors++;
            end
            if (got.no_nb !== want.no_nb) begin
                $error("no_neighbours: expected %0b, actual %0b", want.no_nb, got.no_nb);
                errors++;
            end
            if (got.sat !== want.sat) begin
                $error("saturated: expected %0b, actual %0b", want.sat, got.sat);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last_result: expected %0b, actual %0b", want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return due_means.size();
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic signed [DATA_W-1:0] i_pixel_value;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic signed [DATA_W-1:0] o_mean_tenths;
    logic                     o_no_neighbours;
    logic                     o_saturated;
    logic                     o_last_result;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;

    mean_scoreboard board;
    int items_sent;
    int send_idle_pct = 25;
    int recv_idle_pct = 62;
    int stall_asks;

    neighbour_mean_smooth i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pixel_value   (i_pixel_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_mean_tenths   (o_mean_tenths),
        .o_no_neighbours (o_no_neighbours),
        .o_saturated     (o_saturated),
        .o_last_result   (o_last_result),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // The receiver process also serves requests for one long hold-off of the output.
    initial begin
        int stall_done;
        int stall_left;
        stall_done  = 0;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && stall_done != stall_asks) begin
                stall_done++;
                stall_left = 400;
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_result(mean_result_t'{o_mean_tenths, o_no_neighbours,
                                              o_saturated, o_last_result});
        end
    end

    function automatic logic [DATA_W-1:0] pick_pixel();
        case ($urandom_range(7))
            0: return PIXEL_MAX;
            1: return PIXEL_MIN;
            2, 3: return 32'($urandom_range(60)) - 32'd30;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_pixel(input logic [DATA_W-1:0] v);
        if (items_sent < 70) begin
            send_idle_pct = 25;
            recv_idle_pct = 62;
        end else if (items_sent < 140) begin
            send_idle_pct = 62;
            recv_idle_pct = 25;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pixel_value <= v;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_pixel(v);
        items_sent++;
    endtask

    task automatic stream(input int count);
        repeat (count) send_pixel(pick_pixel());
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.note_config(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic reshape(input int rows, input int cols);
        settle();
        write_reg(CFG_ROW_COUNT, 16'(rows));
        write_reg(CFG_COL_COUNT, {10'($urandom), 6'(cols)});
    endtask

    initial begin
        int rows;
        int cols;
        int total;
        int count;
        int pass;
        int small_vals [9] = '{-7, 3, 0, 5, -1, 2, 9, -4, 1};
        board         = new();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_pixel_value = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        items_sent    = 0;
        stall_asks    = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Single elements after reset have no neighbours.
        send_pixel(PIXEL_MAX);
        send_pixel(PIXEL_MIN);
        // Saturation at both ends, and a second matrix with the same sizes.
        reshape(2, 2);
        repeat (4) send_pixel(PIXEL_MAX);
        repeat (4) send_pixel(PIXEL_MIN);
        reshape(3, 3);
        foreach (small_vals[i]) send_pixel(32'(small_vals[i]));
        reshape(0, 0);
        send_pixel(pick_pixel());
        // A write to an unused index must not restart the matrix.
        reshape(2, 3);
        stream(3);
        settle();
        write_reg(CFG_SPARE, 16'hA5A5);
        stream(3);
        // The widest matrix overflows the final flush and holds one result back.
        reshape(2, 63);
        stream(126);
        reshape(65535, 1);
        stream(6);

        pass = 0;
        while (items_sent < 205) begin
            rows = $urandom_range(1, 4);
            cols = $urandom_range(1, 6);
            case ($urandom_range(9))
                0: cols = $urandom_range(7, 24);
                1: rows = 0;
                2: cols = 0;
                3: begin
                    rows = $urandom_range(5, 12);
                    cols = $urandom_range(1, 3);
                end
                default: ;
            endcase
            if (pass == 0) begin
                rows = 4;
                cols = 6;
            end
            reshape(rows, cols);
            if (pass == 0) stall_asks++;
            total = (rows == 0 ? 1 : rows) * (cols == 0 ? 1 : cols);
            count = total;
            if (total > 1 && $urandom_range(5) == 0) begin
                count = $urandom_range(1, total - 1);
            end else if ($urandom_range(4) == 0) begin
                count = 2 * total;
            end
            if (count > 212 - items_sent) begin
                count = 212 - items_sent;
            end
            stream(count);
            pass++;
        end

        settle();
        if (board.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
